// ===== hdl/lvau_pkg.sv =====
// Shared types, constants and helpers for the Langevin velocity-Verlet axis update.
// Used by lvau_regs and langevin_verlet_axis_update; depends on nothing else.
package lvau_pkg;

  // APB register file geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_W  = 31;

  // Q16.16 fixed point
  localparam int Q_FRAC = 16;

  // 1/(2*sqrt(3)) in Q16.16, rounded to nearest
  localparam logic signed [31:0] PF_Q = 32'sd18919;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_TIME_STEP      = 3'd0,
    REG_HALF_STEP      = 3'd1,
    REG_HALF_STEP_SQ   = 3'd2,
    REG_FRICTION       = 3'd3,
    REG_FRICTION_STEP  = 3'd4,
    REG_NOISE_POS_GAIN = 3'd5,
    REG_NOISE_VEL_GAIN = 3'd6
  } reg_idx_t;

  // coefficient set handed from the register file to the datapath
  typedef struct packed {
    logic [REG_W-1:0] time_step;
    logic [REG_W-1:0] half_step;
    logic [REG_W-1:0] half_step_sq;
    logic [REG_W-1:0] friction;
    logic [REG_W-1:0] friction_step;
    logic [REG_W-1:0] noise_pos_gain;
    logic [REG_W-1:0] noise_vel_gain;
  } cfg_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > S32_MAX) begin
      res = 32'sh7fffffff;
    end else if (x < S32_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = 32'(x);
    end
    return res;
  endfunction

endpackage

// ===== hdl/lvau_regs.sv =====
// APB-style coefficient register file for the Langevin axis update.
// Depends on lvau_pkg (cfg_t, reg_idx_t, widths).
module lvau_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lvau_pkg::ADDR_W-1:0]   paddr,
  input  logic [lvau_pkg::DATA_W-1:0]   pwdata,
  output logic [lvau_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lvau_pkg::cfg_t                cfg
);

  lvau_pkg::cfg_t     cfg_r;
  lvau_pkg::cfg_t     cfg_nxt;
  lvau_pkg::reg_idx_t idx;
  logic               wr_en;
  logic [lvau_pkg::REG_W-1:0] wval;
  logic [lvau_pkg::REG_W-1:0] rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lvau_pkg::reg_idx_t'(paddr[4:2]);
  assign wval   = pwdata[lvau_pkg::REG_W-1:0];

  // write decode; the unused index is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        lvau_pkg::REG_TIME_STEP:      cfg_nxt.time_step      = wval;
        lvau_pkg::REG_HALF_STEP:      cfg_nxt.half_step      = wval;
        lvau_pkg::REG_HALF_STEP_SQ:   cfg_nxt.half_step_sq   = wval;
        lvau_pkg::REG_FRICTION:       cfg_nxt.friction       = wval;
        lvau_pkg::REG_FRICTION_STEP:  cfg_nxt.friction_step  = wval;
        lvau_pkg::REG_NOISE_POS_GAIN: cfg_nxt.noise_pos_gain = wval;
        lvau_pkg::REG_NOISE_VEL_GAIN: cfg_nxt.noise_vel_gain = wval;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      lvau_pkg::REG_TIME_STEP:      rval = cfg_r.time_step;
      lvau_pkg::REG_HALF_STEP:      rval = cfg_r.half_step;
      lvau_pkg::REG_HALF_STEP_SQ:   rval = cfg_r.half_step_sq;
      lvau_pkg::REG_FRICTION:       rval = cfg_r.friction;
      lvau_pkg::REG_FRICTION_STEP:  rval = cfg_r.friction_step;
      lvau_pkg::REG_NOISE_POS_GAIN: rval = cfg_r.noise_pos_gain;
      lvau_pkg::REG_NOISE_VEL_GAIN: rval = cfg_r.noise_vel_gain;
      default:                      rval = '0;
    endcase
  end

  assign prdata = {1'b0, rval};
  assign cfg    = cfg_r;

endmodule

// ===== hdl/langevin_verlet_axis_update.sv =====
// Langevin velocity-Verlet per-axis update, Q16.16, five register stages.
// An accepted item passes stage 1..4 and then the output register, which drives out_valid.
// Throughput: one item per cycle unless out_stall backs up the pipeline; stage depth is
// set by one multiply of about 32x32 bits and a saturating add. Each stage advances
// whenever the next one is free, so bubbles fill under out_stall. Reset (rst_n low,
// synchronous) clears all valid bits and the coefficient registers. Depends on lvau_pkg
// and lvau_regs.
module langevin_verlet_axis_update (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic signed [31:0]          in_position,
  input  logic signed [31:0]          in_velocity,
  input  logic signed [31:0]          in_force_now,
  input  logic signed [31:0]          in_force_before,
  input  logic signed [31:0]          in_noise_xi,
  input  logic signed [31:0]          in_noise_theta,
  input  logic signed [31:0]          in_correction_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_new_position,
  output logic signed [31:0]          out_new_velocity,
  output logic signed [31:0]          out_correction,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lvau_pkg::ADDR_W-1:0] paddr,
  input  logic [lvau_pkg::DATA_W-1:0] pwdata,
  output logic [lvau_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  lvau_pkg::cfg_t cfg;

  lvau_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------- pipeline control ----------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out;

  assign en_out   = !out_valid_r || !out_stall;
  assign en4      = !v4_r || en_out;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- stage 1: first products, force sum ----------------
  // drift: gamma*v, PF*theta, v*dt   kick: gdt*v, nvel*xi, gamma*cin
  logic [30:0]        op_a, op_c;
  logic signed [31:0] op_b1, op_b2, op_c2;
  logic signed [63:0] prod_a, prod_b, prod_c;
  logic signed [47:0] s1_pa_nxt, s1_pb_nxt, s1_pc_nxt;
  logic signed [32:0] s1_sum_nxt;

  always_comb begin
    op_a  = in_mode ? cfg.friction_step : cfg.friction;
    op_b1 = in_mode ? signed'({1'b0, cfg.noise_vel_gain}) : lvau_pkg::PF_Q;
    op_b2 = in_mode ? in_noise_xi : in_noise_theta;
    op_c  = in_mode ? cfg.friction : cfg.time_step;
    op_c2 = in_mode ? in_correction_in : in_velocity;
    prod_a = 64'(signed'({1'b0, op_a})) * 64'(in_velocity);
    prod_b = 64'(op_b1) * 64'(op_b2);
    prod_c = 64'(signed'({1'b0, op_c})) * 64'(op_c2);
    s1_pa_nxt  = 48'(prod_a >>> lvau_pkg::Q_FRAC);
    s1_pb_nxt  = 48'(prod_b >>> lvau_pkg::Q_FRAC);
    s1_pc_nxt  = 48'(prod_c >>> lvau_pkg::Q_FRAC);
    s1_sum_nxt = 33'(in_force_now) + 33'(in_force_before);
  end

  logic               s1_kick_r;
  logic signed [31:0] s1_pos_r, s1_vel_r, s1_fn_r, s1_xi_r, s1_cin_r;
  logic signed [47:0] s1_pa_r, s1_pb_r, s1_pc_r;
  logic signed [32:0] s1_sum_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_kick_r <= in_mode;
      s1_pos_r  <= in_position;
      s1_vel_r  <= in_velocity;
      s1_fn_r   <= in_force_now;
      s1_xi_r   <= in_noise_xi;
      s1_cin_r  <= in_correction_in;
      s1_pa_r   <= s1_pa_nxt;
      s1_pb_r   <= s1_pb_nxt;
      s1_pc_r   <= s1_pc_nxt;
      s1_sum_r  <= s1_sum_nxt;
    end
  end

  // ---------------- stage 2: drift a and n, kick half-step product ----------------
  logic signed [31:0] s2_g, s2_a_nxt, s2_n_nxt;
  logic signed [63:0] prod_d;
  logic signed [48:0] s2_d_nxt;
  logic signed [49:0] s2_kacc, s2_acc_nxt;

  always_comb begin
    s2_g     = lvau_pkg::sat32(64'(s1_pa_r));
    s2_a_nxt = lvau_pkg::sat32(64'(s1_fn_r) - 64'(s2_g));
    s2_n_nxt = lvau_pkg::sat32(64'(s1_xi_r >>> 1) + 64'(s1_pb_r));
    prod_d   = 64'(signed'({1'b0, cfg.half_step})) * 64'(s1_sum_r);
    s2_d_nxt = 49'(prod_d >>> lvau_pkg::Q_FRAC);
    s2_kacc  = 50'(s1_vel_r) - 50'(s1_pa_r) + 50'(s1_pb_r) - 50'(s1_pc_r);
    // drift carries v*dt in the accumulator
    s2_acc_nxt = s1_kick_r ? s2_kacc : 50'(s1_pc_r);
  end

  logic               s2_kick_r;
  logic signed [31:0] s2_pos_r, s2_vel_r, s2_cin_r, s2_a_r, s2_n_r;
  logic signed [48:0] s2_d_r;
  logic signed [49:0] s2_acc_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_kick_r <= s1_kick_r;
      s2_pos_r  <= s1_pos_r;
      s2_vel_r  <= s1_vel_r;
      s2_cin_r  <= s1_cin_r;
      s2_a_r    <= s2_a_nxt;
      s2_n_r    <= s2_n_nxt;
      s2_d_r    <= s2_d_nxt;
      s2_acc_r  <= s2_acc_nxt;
    end
  end

  // ---------------- stage 3: drift correction products, kick final sum ----------------
  logic signed [63:0] prod_m1, prod_m2;
  logic signed [47:0] s3_m1_nxt, s3_m2_nxt, s3_vdt_nxt;
  logic signed [31:0] s3_vel_nxt;

  always_comb begin
    prod_m1    = 64'(signed'({1'b0, cfg.half_step_sq})) * 64'(s2_a_r);
    prod_m2    = 64'(signed'({1'b0, cfg.noise_pos_gain})) * 64'(s2_n_r);
    s3_m1_nxt  = 48'(prod_m1 >>> lvau_pkg::Q_FRAC);
    s3_m2_nxt  = 48'(prod_m2 >>> lvau_pkg::Q_FRAC);
    s3_vdt_nxt = 48'(s2_acc_r);
    s3_vel_nxt = s2_kick_r ? lvau_pkg::sat32(64'(s2_acc_r) + 64'(s2_d_r)) : s2_vel_r;
  end

  logic               s3_kick_r;
  logic signed [31:0] s3_pos_r, s3_vel_r, s3_cin_r;
  logic signed [47:0] s3_m1_r, s3_m2_r, s3_vdt_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_kick_r <= s2_kick_r;
      s3_pos_r  <= s2_pos_r;
      s3_vel_r  <= s3_vel_nxt;
      s3_cin_r  <= s2_cin_r;
      s3_m1_r   <= s3_m1_nxt;
      s3_m2_r   <= s3_m2_nxt;
      s3_vdt_r  <= s3_vdt_nxt;
    end
  end

  // ---------------- stage 4: correction term ----------------
  logic signed [31:0] s4_corr_nxt;

  always_comb begin
    s4_corr_nxt = s3_kick_r ? s3_cin_r
                            : lvau_pkg::sat32(64'(s3_m1_r) + 64'(s3_m2_r));
  end

  logic               s4_kick_r;
  logic signed [31:0] s4_pos_r, s4_vel_r, s4_corr_r;
  logic signed [47:0] s4_vdt_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_kick_r <= s3_kick_r;
      s4_pos_r  <= s3_pos_r;
      s4_vel_r  <= s3_vel_r;
      s4_corr_r <= s4_corr_nxt;
      s4_vdt_r  <= s3_vdt_r;
    end
  end

  // ---------------- output register: new position ----------------
  logic signed [31:0] out_pos_nxt;
  logic signed [31:0] out_pos_r, out_vel_r, out_corr_r;

  always_comb begin
    out_pos_nxt = s4_kick_r ? s4_pos_r
                            : lvau_pkg::sat32(64'(s4_pos_r) + 64'(s4_vdt_r)
                                              + 64'(s4_corr_r));
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_pos_r  <= out_pos_nxt;
      out_vel_r  <= s4_vel_r;
      out_corr_r <= s4_corr_r;
    end
  end

  assign out_new_position = out_pos_r;
  assign out_new_velocity = out_vel_r;
  assign out_correction   = out_corr_r;

  // ---------------- assertions ----------------
  // an empty pipeline never pushes back
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && !v2_r && !v3_r && !v4_r && !out_valid_r) |-> !in_stall)
    else $error("input stalled while pipeline empty");

  // an accepted transfer lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted item lost at stage 1");

  // a blocked stage keeps its item
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en4) |=> (v3_r && $stable(s3_vel_r)))
    else $error("stage 3 item dropped or changed under backpressure");

  // last stage holds its payload while the output register is blocked
  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !en_out) |=> (v4_r && $stable(s4_corr_r) && $stable(s4_pos_r)))
    else $error("stage 4 item dropped or changed under backpressure");

endmodule
